// File: rtl/core/jrew_pkg.sv
// Package for the jog ramp controller with effort watchdog.
// Holds the item, result and register types and the fixed codes and resets.
// No dependencies; used by every module of the block but jrew_checker.
package jrew_pkg;

   // Item kinds
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_KICK  = 2'd1,
      ACT_PULSE = 2'd2,
      ACT_LOAD  = 2'd3
   } action_type;

   // Jog codes; the fourth code behaves as no jog
   localparam logic [1:0] JOG_CW  = 2'd1;
   localparam logic [1:0] JOG_CCW = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_WDOG_RELOAD  = 2'd0;
   localparam logic [1:0] REG_RAMP_STEP    = 2'd1;
   localparam logic [1:0] REG_RAMP_CEILING = 2'd2;

   // Register reset values
   localparam logic [15:0] WDOG_RELOAD_RESET  = 16'd1;
   localparam logic [7:0]  RAMP_STEP_RESET    = 8'd2;
   localparam logic [13:0] RAMP_CEILING_RESET = 14'd10000;

   // Effort curve shifts
   localparam int EFFORT_SHIFT_HI = 7;
   localparam int EFFORT_SHIFT_LO = 9;

   typedef struct packed {
      logic [15:0] wdog_reload;
      logic [7:0]  ramp_step;
      logic [13:0] ramp_ceiling;
   } cfg_type;

   typedef struct packed {
      action_type         action;
      logic [1:0]         jog_request;
      logic signed [15:0] position_value;
   } item_type;

   typedef struct packed {
      logic signed [14:0] ramp_now;
      logic signed [15:0] position;
      logic               watchdog_stop;
      logic               direction_ccw;
      logic [7:0]         effort;
   } result_type;

endpackage

// File: rtl/core/jog_ramp_effort_watchdog.sv
// Top level of the jog ramp controller with effort watchdog.
// Depends on jrew_pkg, jrew_csr and jrew_core.
//
// Each accepted item (tick, watchdog kick, encoder pulse or position load)
// yields exactly one result. An accepted item waits in the input register
// until the output register is free; its result is then registered in the
// output register and offered from there. While results are taken, one item is
// taken every cycle: the item is captured in an input register, the controller state
// (ramp, effort, direction, watchdog count, position) is updated by jrew_core
// as the item moves on, and the result lands in an output register. A stalled
// result holds the output register; the input register then fills with one
// more item and req_tready drops until the result is taken. Registers are
// written through the APB-style port and take effect on the next item; write
// them only while no item is in flight. A new watchdog reload value reaches
// the count at the next kick.
module jog_ramp_effort_watchdog (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [1:0] jog_request, [17:2] position_value, rest zero
   input  logic [1:0]  req_tuser,  // [1:0] action
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [7:0] effort, [8] direction_ccw, [9] watchdog_stop,
                                   // [25:10] position, [40:26] ramp_now, rest zero
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   jrew_pkg::cfg_type    cfg;
   jrew_pkg::item_type   item_ff, item_in;
   jrew_pkg::result_type res, rsp_ff;
   logic                 s0_valid_ff, s0_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 adv_out, item_en, req_acc;

   jrew_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Pipeline handshake: output register frees, input stage moves along
   assign adv_out    = !rsp_valid_ff || rsp_tready;
   assign item_en    = s0_valid_ff && adv_out;
   assign req_tready = !s0_valid_ff || adv_out;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      item_in.action         = jrew_pkg::action_type'(req_tuser);
      item_in.jog_request    = req_tdata[1:0];
      item_in.position_value = req_tdata[17:2];
      s0_valid_in  = req_acc ? 1'b1 : (item_en ? 1'b0 : s0_valid_ff);
      rsp_valid_in = item_en ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   jrew_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item_en (item_en),
      .item    (item_ff),
      .cfg     (cfg),
      .res     (res)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         item_ff <= item_in;
      end
      if (item_en) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};

endmodule

// File: rtl/core/jrew_csr.sv
// Configuration registers of the jog ramp controller, APB-style access.
// Depends on jrew_pkg for register indexes, resets and cfg_type.
module jrew_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output jrew_pkg::cfg_type  cfg
);

   jrew_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[3:2])
            jrew_pkg::REG_WDOG_RELOAD:  cfg_in.wdog_reload  = csr_pwdata[15:0];
            jrew_pkg::REG_RAMP_STEP:    cfg_in.ramp_step    = csr_pwdata[7:0];
            jrew_pkg::REG_RAMP_CEILING: cfg_in.ramp_ceiling = csr_pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wdog_reload  <= jrew_pkg::WDOG_RELOAD_RESET;
         cfg_ff.ramp_step    <= jrew_pkg::RAMP_STEP_RESET;
         cfg_ff.ramp_ceiling <= jrew_pkg::RAMP_CEILING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read decode
   always_comb begin
      unique case (csr_paddr[3:2])
         jrew_pkg::REG_WDOG_RELOAD:  csr_prdata = {16'd0, cfg_ff.wdog_reload};
         jrew_pkg::REG_RAMP_STEP:    csr_prdata = {24'd0, cfg_ff.ramp_step};
         jrew_pkg::REG_RAMP_CEILING: csr_prdata = {18'd0, cfg_ff.ramp_ceiling};
         default:                    csr_prdata = 32'd0;
      endcase
   end

endmodule

// File: rtl/core/jrew_core.sv
// Controller state and its update for one item.
// Depends on jrew_pkg for item, result and register types.
module jrew_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_en,
   input  jrew_pkg::item_type   item,
   input  jrew_pkg::cfg_type    cfg,
   output jrew_pkg::result_type res
);

   logic signed [14:0] ramp_ff, ramp_in;
   logic [7:0]         effort_ff, effort_in;
   logic               dir_ff, dir_in;
   logic [15:0]        wdog_ff, wdog_in;
   logic [15:0]        pos_ff, pos_in;

   logic signed [16:0] v_cur, v_new, v_sum, v_dif, ceil_pos, ceil_neg, step_ext;
   logic               ramp_upd;
   logic               stop;
   logic [15:0]        mag;
   logic [8:0]         eff_sum;

   // Ramp arithmetic, widened so sums never overflow
   always_comb begin
      v_cur    = {{2{ramp_ff[14]}}, ramp_ff};
      ceil_pos = {3'b000, cfg.ramp_ceiling};
      ceil_neg = -ceil_pos;
      step_ext = {9'd0, cfg.ramp_step};
      v_sum    = v_cur + step_ext;
      v_dif    = v_cur - step_ext;
   end

   // Next ramp value for a tick
   always_comb begin
      ramp_upd = 1'b1;
      case (item.jog_request)
         jrew_pkg::JOG_CW: begin
            if (v_cur >= ceil_pos || v_sum > ceil_pos) v_new = ceil_pos;
            else v_new = v_sum;
         end
         jrew_pkg::JOG_CCW: begin
            if (v_cur <= ceil_neg || v_dif < ceil_neg) v_new = ceil_neg;
            else v_new = v_dif;
         end
         default: begin
            // no jog: decay one toward zero, hold at zero
            ramp_upd = (v_cur != 17'sd0);
            if (v_cur[16]) v_new = v_cur + 17'sd1;
            else if (ramp_upd) v_new = v_cur - 17'sd1;
            else v_new = v_cur;
         end
      endcase
      mag     = v_new[16] ? 16'(-v_new) : v_new[15:0];
      eff_sum = 9'(mag >> jrew_pkg::EFFORT_SHIFT_HI)
              + 9'(mag >> jrew_pkg::EFFORT_SHIFT_LO) + 9'd1;
   end

   // State update per item kind
   always_comb begin
      ramp_in   = ramp_ff;
      effort_in = effort_ff;
      dir_in    = dir_ff;
      wdog_in   = wdog_ff;
      pos_in    = pos_ff;
      stop      = 1'b0;
      unique case (item.action)
         jrew_pkg::ACT_TICK: begin
            // watchdog first, then the ramp may set effort again
            if (effort_ff != 8'd0) begin
               if (wdog_ff == 16'd0) begin
                  effort_in = 8'd0;
                  stop      = 1'b1;
               end else begin
                  wdog_in = wdog_ff - 16'd1;
               end
            end
            if (ramp_upd) begin
               ramp_in   = v_new[14:0];
               dir_in    = v_new[16];
               effort_in = eff_sum[7:0];
            end
         end
         jrew_pkg::ACT_KICK:  wdog_in = cfg.wdog_reload;
         jrew_pkg::ACT_PULSE: pos_in  = dir_ff ? pos_ff - 16'd1 : pos_ff + 16'd1;
         jrew_pkg::ACT_LOAD:  pos_in  = item.position_value;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff   <= 15'sd0;
         effort_ff <= 8'd0;
         dir_ff    <= 1'b0;
         wdog_ff   <= jrew_pkg::WDOG_RELOAD_RESET;
         pos_ff    <= 16'd0;
      end else if (item_en) begin
         ramp_ff   <= ramp_in;
         effort_ff <= effort_in;
         dir_ff    <= dir_in;
         wdog_ff   <= wdog_in;
         pos_ff    <= pos_in;
      end
   end

   // Result reflects the state after this item
   always_comb begin
      res.ramp_now      = ramp_in;
      res.position      = pos_in;
      res.watchdog_stop = stop;
      res.direction_ccw = dir_in;
      res.effort        = effort_in;
   end

endmodule

// File: rtl/core/jrew_checker.sv
// Port-level checks for the jog ramp controller, bound to the top level.
// Depends only on the ports of jog_ramp_effort_watchdog.
module jrew_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A negative ramp always carries the counterclockwise direction
   a_dir_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[40] |-> rsp_tdata[8])
      else $error("negative ramp with clockwise direction");

   // Effort never exceeds the curve at the largest ramp magnitude
   a_effort_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] <= 8'd159)
      else $error("effort out of range");

   // Ramp stays symmetric: the most negative 15-bit code never appears
   a_ramp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[40:26] != 15'h4000 && rsp_tdata[47:41] == 7'd0)
      else $error("ramp out of range or padding set");

endmodule

bind jog_ramp_effort_watchdog jrew_checker u_jrew_checker (.*);

// File: sim/jog_ramp_effort_watchdog_tb.sv
// Self-checking testbench for jog_ramp_effort_watchdog: stream items in, one result each out.
// A tracker class mirrors the ramp, effort, watchdog and position state and checks every result.
// Depends on jrew_pkg and the block's RTL only.
`timescale 1ns / 1ps

module jog_ramp_effort_watchdog_tb;

   // jog codes the package does not name
   localparam logic [1:0] JOG_IDLE  = 2'd0;
   localparam logic [1:0] JOG_SPARE = 2'd3;
   // register index past the end of the map
   localparam logic [1:0] REG_SPARE = 2'd3;

   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS   = 104;

   // Tracks controller state and holds the results still to come
   class jog_ramp_tracker;
      logic [15:0] wd_top;
      logic [7:0]  step;
      logic [13:0] ceiling;
      int          ramp;
      logic [7:0]  effort;
      logic        ccw;
      logic [15:0] wd_count;
      logic [15:0] pos;
      jrew_pkg::result_type pending_results[$];
      int          error_count;

      function new();
         wd_top      = jrew_pkg::WDOG_RELOAD_RESET;
         step        = jrew_pkg::RAMP_STEP_RESET;
         ceiling     = jrew_pkg::RAMP_CEILING_RESET;
         ramp        = 0;
         effort      = 8'd0;
         ccw         = 1'b0;
         wd_count    = jrew_pkg::WDOG_RELOAD_RESET;
         pos         = 16'd0;
         error_count = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [31:0] value);
         case (index)
            jrew_pkg::REG_WDOG_RELOAD:  wd_top = value[15:0];
            jrew_pkg::REG_RAMP_STEP:    step = value[7:0];
            jrew_pkg::REG_RAMP_CEILING: ceiling = value[13:0];
            default: ;
         endcase
      endfunction

      // new ramp value sets direction and the effort curve
      function void steer(int v);
         int mag;
         ramp   = v;
         ccw    = (v < 0);
         mag    = (v < 0) ? -v : v;
         effort = 8'((mag >> 7) + (mag >> 9) + 1);
      endfunction

      function void apply_item(jrew_pkg::item_type it);
         jrew_pkg::result_type r;
         logic       stop;
         int         v;
         int         c;
         int         s;
         stop = 1'b0;
         v    = ramp;
         c    = ceiling;
         s    = step;
         case (it.action)
            jrew_pkg::ACT_TICK: begin
               // watchdog runs before the ramp
               if (effort != 8'd0) begin
                  if (wd_count == 16'd0) begin
                     effort = 8'd0;
                     stop   = 1'b1;
                  end else begin
                     wd_count = wd_count - 16'd1;
                  end
               end
               if (it.jog_request == jrew_pkg::JOG_CW) begin
                  steer((v >= c || v + s > c) ? c : v + s);
               end else if (it.jog_request == jrew_pkg::JOG_CCW) begin
                  steer((v <= -c || v - s < -c) ? -c : v - s);
               end else if (v != 0) begin
                  steer((v < 0) ? v + 1 : v - 1);
               end
            end
            jrew_pkg::ACT_KICK:  wd_count = wd_top;
            jrew_pkg::ACT_PULSE: pos = ccw ? pos - 16'd1 : pos + 16'd1;
            jrew_pkg::ACT_LOAD:  pos = it.position_value;
         endcase
         r.effort        = effort;
         r.direction_ccw = ccw;
         r.watchdog_stop = stop;
         r.position      = pos;
         r.ramp_now      = ramp[14:0];
         pending_results.push_back(r);
      endfunction

      function void check_field(string field, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
         end
      endfunction

      function void check_result(logic [47:0] data);
         jrew_pkg::result_type got;
         jrew_pkg::result_type want;
         got = data[40:0];
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %h",
                     $time, data);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         check_field("effort", want.effort, got.effort);
         check_field("direction_ccw", want.direction_ccw, got.direction_ccw);
         check_field("watchdog_stop", want.watchdog_stop, got.watchdog_stop);
         check_field("position", $signed(want.position), $signed(got.position));
         check_field("ramp_now", $signed(want.ramp_now), $signed(got.ramp_now));
         check_field("padding", 0, data[47:41]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [1:0] jog_request, [17:2] position_value, rest zero
   logic [1:0]  req_tuser = '0;   // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [7:0] effort, [8] direction_ccw, [9] watchdog_stop,
                                  // [25:10] position, [40:26] ramp_now, rest zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   jog_ramp_tracker tracker = new();

   bit          send_gap_on = 1'b1;
   bit          take_gap_on = 1'b1;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;
   logic [1:0]  burst_jog = JOG_IDLE;
   int          burst_left = 0;

   jog_ramp_effort_watchdog u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one item after a random gap, return at the edge it is taken
   task automatic send_item(input jrew_pkg::action_type act, input logic [1:0] jog,
                            input logic [15:0] value);
      int gap;
      gap = send_gap_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, value, jog};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait for every result, then let the pipe settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      // let the monitor note the last accepted item before checking the queue
      @(posedge clock);
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup phase, access phase, then idle with psel low
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_register(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Per-phase register settings; odd phases carry junk in the unused upper bits
   task automatic configure(input int phase);
      logic [31:0] wd;
      logic [31:0] st;
      logic [31:0] ce;
      wd = phase[0] ? $urandom() : 32'd0;
      st = phase[0] ? $urandom() : 32'd0;
      ce = phase[0] ? $urandom() : 32'd0;
      case (phase)
         0: begin
            wd[15:0] = 16'hFFFF;
            st[7:0]  = 8'd255;
            ce[13:0] = 14'd16383;
         end
         1: begin
            wd[15:0] = 16'd0;
            st[7:0]  = 8'd1;
            ce[13:0] = 14'd1;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: wd[15:0] = 16'd0;
               1: wd[15:0] = 16'hFFFF;
               2: wd[15:0] = 16'($urandom_range(1, 20));
               default: wd[15:0] = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 5))
               0: st[7:0] = 8'd0;
               1: st[7:0] = 8'd1;
               2: st[7:0] = 8'd255;
               default: st[7:0] = 8'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 5))
               0: ce[13:0] = 14'd0;
               1: ce[13:0] = 14'd1;
               2: ce[13:0] = 14'd16383;
               3: ce[13:0] = 14'd16000;
               default: ce[13:0] = 14'($urandom_range(1, 16383));
            endcase
         end
      endcase
      write_reg(jrew_pkg::REG_WDOG_RELOAD, wd);
      write_reg(jrew_pkg::REG_RAMP_STEP, st);
      write_reg(jrew_pkg::REG_RAMP_CEILING, ce);
   endtask

   // Mostly bursts of ticks with one jog code, mixed with kicks, pulses and loads
   function automatic jrew_pkg::item_type draw_item();
      jrew_pkg::item_type it;
      int       roll;
      roll              = $urandom_range(0, 99);
      it.jog_request    = 2'($urandom_range(0, 3));
      it.position_value = 16'($urandom());
      if (roll < 60) begin
         if (burst_left == 0) begin
            burst_jog  = 2'($urandom_range(0, 3));
            burst_left = $urandom_range(1, 70);
         end
         burst_left--;
         it.action      = jrew_pkg::ACT_TICK;
         it.jog_request = burst_jog;
      end else if (roll < 75) begin
         it.action = jrew_pkg::ACT_KICK;
      end else if (roll < 88) begin
         it.action = jrew_pkg::ACT_PULSE;
      end else begin
         it.action = jrew_pkg::ACT_LOAD;
      end
      return it;
   endfunction

   // Result side: random stalls, plus a long hold-off on request
   initial begin : result_sink
      int stall;
      int n;
      repeat (3) @(posedge clock);
      forever begin
         if (hold_cycles != 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            stall = take_gap_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            do @(posedge clock);
            while (!(rsp_tvalid && rsp_tready) && hold_cycles == 0);
         end
      end
   end

   // Handshake monitor and stall watchdog
   always @(posedge clock) begin : monitor
      jrew_pkg::item_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.action         = jrew_pkg::action_type'(req_tuser);
            seen.jog_request    = req_tdata[1:0];
            seen.position_value = req_tdata[17:2];
            tracker.apply_item(seen);
         end
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      jrew_pkg::item_type it;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default settings: wrap, reverse jog, watchdog expiry, return to zero
      send_item(jrew_pkg::ACT_TICK, JOG_IDLE, 16'h0000);
      send_item(jrew_pkg::ACT_PULSE, JOG_IDLE, 16'hFFFF);
      send_item(jrew_pkg::ACT_LOAD, jrew_pkg::JOG_CW, 16'h7FFF);
      send_item(jrew_pkg::ACT_PULSE, jrew_pkg::JOG_CCW, 16'h0000);
      send_item(jrew_pkg::ACT_TICK, jrew_pkg::JOG_CCW, 16'h5555);
      send_item(jrew_pkg::ACT_PULSE, JOG_IDLE, 16'hAAAA);
      send_item(jrew_pkg::ACT_TICK, JOG_SPARE, 16'h0000);
      send_item(jrew_pkg::ACT_TICK, JOG_IDLE, 16'h0000);
      send_item(jrew_pkg::ACT_TICK, JOG_IDLE, 16'h0000);
      send_item(jrew_pkg::ACT_KICK, JOG_SPARE, 16'hFFFF);
      send_item(jrew_pkg::ACT_LOAD, JOG_SPARE, 16'h8000);
      wait_drained();

      // top of every register, junk above the reload field, spare index ignored
      write_reg(jrew_pkg::REG_WDOG_RELOAD, 32'hFFFF_FFFF);
      write_reg(jrew_pkg::REG_RAMP_STEP, 32'd255);
      write_reg(jrew_pkg::REG_RAMP_CEILING, 32'd16383);
      write_reg(REG_SPARE, $urandom());
      send_item(jrew_pkg::ACT_KICK, JOG_IDLE, 16'h0000);
      send_item(jrew_pkg::ACT_TICK, jrew_pkg::JOG_CW, 16'h0000);
      send_item(jrew_pkg::ACT_TICK, jrew_pkg::JOG_CW, 16'h0000);
      wait_drained();

      // ceiling dropped below the ramp, then a zero step
      write_reg(jrew_pkg::REG_RAMP_CEILING, 32'd5);
      write_reg(jrew_pkg::REG_RAMP_STEP, 32'd0);
      send_item(jrew_pkg::ACT_TICK, jrew_pkg::JOG_CW, 16'h0000);
      send_item(jrew_pkg::ACT_TICK, jrew_pkg::JOG_CCW, 16'h0000);
      wait_drained();

      // zero ceiling pins the ramp at zero
      write_reg(jrew_pkg::REG_RAMP_CEILING, 32'd0);
      write_reg(jrew_pkg::REG_RAMP_STEP, 32'd255);
      send_item(jrew_pkg::ACT_TICK, jrew_pkg::JOG_CCW, 16'h0000);
      send_item(jrew_pkg::ACT_TICK, jrew_pkg::JOG_CW, 16'h0000);
      send_item(jrew_pkg::ACT_TICK, JOG_IDLE, 16'h0000);
      wait_drained();

      // zero reload: stop and re-arm in the same tick
      write_reg(jrew_pkg::REG_WDOG_RELOAD, 32'd0);
      write_reg(jrew_pkg::REG_RAMP_STEP, 32'd1);
      write_reg(jrew_pkg::REG_RAMP_CEILING, 32'd16383);
      send_item(jrew_pkg::ACT_KICK, JOG_IDLE, 16'h0000);
      send_item(jrew_pkg::ACT_TICK, jrew_pkg::JOG_CW, 16'h0000);
      wait_drained();

      // random phases, each under its own settings
      for (int phase = 0; phase < 8; phase++) begin
         configure(phase);
         send_gap_on = (phase % 3 != 2);
         take_gap_on = (phase % 4 != 1);
         if (phase == 3) begin
            // result side held off while items keep coming
            send_gap_on = 1'b0;
            hold_cycles = 80;
         end
         repeat (PHASE_ITEMS) begin
            it = draw_item();
            send_item(it.action, it.jog_request, it.position_value);
         end
         wait_drained();
      end

      if (tracker.error_count == 0 && tracker.pending_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/jrew_pkg.sv
rtl/core/jrew_csr.sv
rtl/core/jrew_core.sv
rtl/core/jog_ramp_effort_watchdog.sv
rtl/core/jrew_checker.sv
sim/jog_ramp_effort_watchdog_tb.sv
